// ===== src/qbt_pkg.sv =====
// ----------------------------------------------------------------------------
// qbt_pkg
// Shared types and character codes for the quote/bracket tokenizer.
// ----------------------------------------------------------------------------
package qbt_pkg;

  // Token length field, wide enough for the largest supported buffer (63).
  localparam int unsigned TOK_LEN_W = 6;
  // Token buffers rotate over three banks.
  localparam int unsigned NUM_BANKS = 3;

  typedef logic [1:0] bank_t;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;

  // One token to stream out; has_extra adds a one-byte plain token after it.
  typedef struct packed {
    bank_t                bank;
    logic [TOK_LEN_W-1:0] len;
    logic                 bracket;
    logic                 quoted;
    logic                 trunc;
    logic                 has_extra;
    logic [7:0]           extra_char;
  } cmd_t;

  // Token buffer write, front to back.
  typedef struct packed {
    logic                 en;
    bank_t                bank;
    logic [TOK_LEN_W-1:0] idx;
    logic [7:0]           data;
  } wr_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]});
  endfunction

  function automatic bank_t next_bank(input bank_t b);
    return (b == bank_t'(NUM_BANKS - 1)) ? bank_t'(0) : b + bank_t'(1);
  endfunction

endpackage

// ===== src/qbt_if.sv =====
// ----------------------------------------------------------------------------
// qbt_in_if / qbt_out_if
// Valid/ready channels of the tokenizer: input bytes and token bytes.
// ----------------------------------------------------------------------------
interface qbt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       end_of_line;

  modport source (output valid, char_in, end_of_line, input ready);
  modport sink   (input valid, char_in, end_of_line, output ready);
endinterface

interface qbt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] token_char;
  logic       token_empty;
  logic       token_last;
  logic       token_truncated;

  modport source (output valid, token_char, token_empty, token_last, token_truncated,
                  input ready);
  modport sink   (input valid, token_char, token_empty, token_last, token_truncated,
                  output ready);
endinterface

// ===== src/qbt_front.sv =====
// ----------------------------------------------------------------------------
// qbt_front
// Parser state machine: classifies each input byte, writes token bytes into
// the buffer banks and queues one command per finished token; a command may also carry a one-byte extra token.
// ----------------------------------------------------------------------------
module qbt_front
  import qbt_pkg::*;
#(
  parameter int unsigned MAX_TOKEN = 48
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  qbt_in_if.sink     in_i,
  input  logic       q_full_i,
  output logic       push_o,
  output cmd_t       cmd_o,
  output wr_t        wr_o
);

  localparam logic [TOK_LEN_W-1:0] MaxLen = TOK_LEN_W'(MAX_TOKEN);

  logic [TOK_LEN_W-1:0] len_q, len_d, len_eff;
  logic                 inq_q, inq_d;
  logic                 inb_q, inb_d;
  logic                 qp_q, qp_d;
  logic                 skip_q, skip_d;
  logic                 ovf_q, ovf_d, ovf_eff;
  bank_t                bank_q, bank_d;

  logic       accept;
  logic [7:0] c;
  logic       app, em_mid, em_br, em_qt, em_eol, do_plain;

  assign in_i.ready = !q_full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign c          = in_i.char_in;

  always_comb begin
    len_d    = len_q;
    inq_d    = inq_q;
    inb_d    = inb_q;
    qp_d     = qp_q;
    skip_d   = skip_q;
    ovf_d    = ovf_q;
    bank_d   = bank_q;
    app      = 1'b0;
    em_mid   = 1'b0;
    em_br    = 1'b0;
    em_qt    = 1'b0;
    em_eol   = 1'b0;
    do_plain = 1'b0;
    len_eff  = len_q;
    ovf_eff  = ovf_q;
    wr_o     = '0;
    cmd_o    = '0;
    push_o   = 1'b0;

    if (accept) begin
      if (skip_q) begin
        // rest of line ignored
      end else if (qp_q) begin
        qp_d = 1'b0;
        if (c == CH_QUOTE) begin
          app = 1'b1;
        end else begin
          em_mid   = 1'b1;
          em_qt    = 1'b1;
          inq_d    = 1'b0;
          do_plain = 1'b1;
        end
      end else if (inq_q) begin
        if (c == CH_QUOTE) qp_d = 1'b1;
        else               app  = 1'b1;
      end else if (inb_q) begin
        if (c == CH_RBRACK) begin
          em_mid = 1'b1;
          em_br  = 1'b1;
          inb_d  = 1'b0;
        end else begin
          app = 1'b1;
        end
      end else begin
        do_plain = 1'b1;
      end

      if (do_plain) begin
        if (c == CH_SEMI) begin
          skip_d = 1'b1;
        end else if (is_space(c)) begin
          // after a mid-item emit the buffer is already empty
          if (!em_mid && (len_q != '0)) em_mid = 1'b1;
        end else if (c == CH_QUOTE) begin
          inq_d = 1'b1;
        end else if (c == CH_LBRACK) begin
          inb_d = 1'b1;
        end else begin
          app = 1'b1;
        end
      end

      len_eff = em_mid ? '0 : len_q;
      ovf_eff = em_mid ? 1'b0 : ovf_q;
      len_d   = len_eff;
      ovf_d   = ovf_eff;

      if (app) begin
        if (len_eff < MaxLen) begin
          wr_o.en   = 1'b1;
          wr_o.bank = em_mid ? next_bank(bank_q) : bank_q;
          wr_o.idx  = len_eff;
          wr_o.data = c;
          len_d     = len_eff + TOK_LEN_W'(1);
        end else begin
          ovf_d = 1'b1;
        end
      end

      cmd_o.bank       = bank_q;
      cmd_o.len        = len_q;
      cmd_o.trunc      = ovf_q;
      cmd_o.bracket    = em_br;
      cmd_o.quoted     = em_qt;
      cmd_o.extra_char = c;

      if (in_i.end_of_line) begin
        if (qp_d) begin
          em_eol       = 1'b1;
          cmd_o.quoted = 1'b1;
        end else if (len_d != '0) begin
          if (em_mid) begin
            // second token of this byte: the byte itself
            cmd_o.has_extra = 1'b1;
          end else begin
            em_eol      = 1'b1;
            cmd_o.len   = len_d;
            cmd_o.trunc = ovf_d;
          end
        end
        len_d  = '0;
        inq_d  = 1'b0;
        inb_d  = 1'b0;
        qp_d   = 1'b0;
        skip_d = 1'b0;
        ovf_d  = 1'b0;
      end

      push_o = em_mid || em_eol;
      if (push_o) bank_d = next_bank(bank_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      inq_q  <= 1'b0;
      inb_q  <= 1'b0;
      qp_q   <= 1'b0;
      skip_q <= 1'b0;
      ovf_q  <= 1'b0;
      bank_q <= '0;
    end else begin
      len_q  <= len_d;
      inq_q  <= inq_d;
      inb_q  <= inb_d;
      qp_q   <= qp_d;
      skip_q <= skip_d;
      ovf_q  <= ovf_d;
      bank_q <= bank_d;
    end
  end

endmodule

// ===== src/qbt_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// qbt_cmd_fifo
// Two-entry command queue between parser and token streamer.
// ----------------------------------------------------------------------------
module qbt_cmd_fifo
  import qbt_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  input  logic pop_i,
  output cmd_t head_o,
  output logic full_o,
  output logic empty_o
);

  cmd_t       slot_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] count_q;

  assign head_o  = slot_q[rptr_q];
  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wptr_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (push_i) wptr_q <= !wptr_q;
      if (pop_i)  rptr_q <= !rptr_q;
      count_q <= count_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

// ===== src/qbt_back.sv =====
// ----------------------------------------------------------------------------
// qbt_back
// Token streamer: owns the banked token buffer, walks each queued command
// byte by byte through a read stage and an output register.
// ----------------------------------------------------------------------------
module qbt_back
  import qbt_pkg::*;
#(
  parameter int unsigned MAX_TOKEN = 48
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  wr_t        wr_i,
  input  cmd_t       cmd_i,
  input  logic       cmd_valid_i,
  output logic       pop_o,
  qbt_out_if.source  out_o
);

  localparam int unsigned DEPTH = NUM_BANKS * MAX_TOKEN;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned PW    = $clog2(MAX_TOKEN + 3);
  localparam int unsigned IW    = (MAX_TOKEN > 1) ? $clog2(MAX_TOKEN) : 1;
  localparam logic [AW-1:0] Base1 = AW'(MAX_TOKEN);
  localparam logic [AW-1:0] Base2 = AW'(2 * MAX_TOKEN);

  logic [7:0] store_q [DEPTH];

  // sequencer
  logic [PW-1:0] pos_q, n_main, sidx;
  logic          xtra_q;
  logic          a_adv, el_last, el_final, el_store, el_empty, el_trunc;
  logic [7:0]    el_char;
  logic [AW-1:0] rd_addr, wr_addr;

  // read stage
  logic       b_valid_q, b_adv, b_store_q, b_empty_q, b_last_q, b_trunc_q;
  logic [7:0] b_char_q, rd_q;

  // output register
  logic       o_valid_q, o_empty_q, o_last_q, o_trunc_q;
  logic [7:0] o_char_q;

  function automatic logic [AW-1:0] bank_base(input bank_t b);
    case (b)
      2'd1:    return Base1;
      2'd2:    return Base2;
      default: return '0;
    endcase
  endfunction

  always_comb begin
    n_main = (cmd_i.quoted && (cmd_i.len == '0))
           ? PW'(1)
           : PW'(cmd_i.len) + (cmd_i.bracket ? PW'(2) : PW'(0));
    sidx     = cmd_i.bracket ? pos_q - PW'(1) : pos_q;
    el_last  = 1'b1;
    el_final = 1'b1;
    el_store = 1'b0;
    el_empty = 1'b0;
    el_trunc = 1'b0;
    el_char  = cmd_i.extra_char;
    if (!xtra_q) begin
      el_last  = (pos_q == n_main - PW'(1));
      el_final = el_last && !cmd_i.has_extra;
      el_trunc = cmd_i.trunc;
      if (cmd_i.quoted && (cmd_i.len == '0)) begin
        el_char  = CH_NUL;
        el_empty = 1'b1;
      end else if (cmd_i.bracket && (pos_q == '0)) begin
        el_char = CH_LBRACK;
      end else if (cmd_i.bracket && el_last) begin
        el_char = CH_RBRACK;
      end else begin
        el_store = 1'b1;
      end
    end
  end

  assign rd_addr = bank_base(cmd_i.bank) + AW'(sidx[IW-1:0]);
  assign wr_addr = bank_base(wr_i.bank) + AW'(wr_i.idx);

  assign b_adv = b_valid_q && (!o_valid_q || out_o.ready);
  assign a_adv = cmd_valid_i && (!b_valid_q || b_adv);
  assign pop_o = a_adv && el_final;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) store_q[wr_addr] <= wr_i.data;
    if (a_adv) begin
      rd_q      <= store_q[rd_addr];
      b_char_q  <= el_char;
      b_store_q <= el_store;
      b_empty_q <= el_empty;
      b_last_q  <= el_last;
      b_trunc_q <= el_trunc;
    end
    if (b_adv) begin
      o_char_q  <= b_store_q ? rd_q : b_char_q;
      o_empty_q <= b_empty_q;
      o_last_q  <= b_last_q;
      o_trunc_q <= b_trunc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      xtra_q    <= 1'b0;
      b_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (a_adv) begin
        if (el_final) begin
          pos_q  <= '0;
          xtra_q <= 1'b0;
        end else if (el_last) begin
          pos_q  <= '0;
          xtra_q <= 1'b1;
        end else begin
          pos_q <= pos_q + PW'(1);
        end
      end
      if (a_adv)      b_valid_q <= 1'b1;
      else if (b_adv) b_valid_q <= 1'b0;
      if (b_adv)             o_valid_q <= 1'b1;
      else if (out_o.ready)  o_valid_q <= 1'b0;
    end
  end

  assign out_o.valid           = o_valid_q;
  assign out_o.token_char      = o_char_q;
  assign out_o.token_empty     = o_empty_q;
  assign out_o.token_last      = o_last_q;
  assign out_o.token_truncated = o_trunc_q;

endmodule

// ===== src/quote_bracket_tokenizer.sv =====
// ----------------------------------------------------------------------------
// quote_bracket_tokenizer
// Splits a script line, one byte per beat, into tokens emitted byte by byte.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  : one line byte per beat (char_in), end_of_line on the final byte.
//   out_o : one token byte per beat; token_last marks a token's final byte,
//           token_empty the single beat of an empty quoted string,
//           token_truncated every byte of a token that lost bytes past
//           MAX_TOKEN.
// Throughput: the parser takes one byte per cycle while the two-entry token
//   queue has room; the streamer sends one token byte per cycle while out_o
//   is not stalled. With tokens waiting in both queue slots, in_i.ready drops
//   until the streamer has fetched the last byte of the oldest one.
// Path: the first byte of a token reaches out_o through the queue, the buffer
//   read stage and the output register.
// Reset: parser flags, queue and pipeline valids clear; buffer contents do
//   not, and no unwritten buffer byte reaches out_o.
// Stall: out_o holds its beat while ready is low; the streamer and then the
//   parser back up behind it without losing data.
// ----------------------------------------------------------------------------
module quote_bracket_tokenizer
  import qbt_pkg::*;
#(
  parameter int unsigned MAX_TOKEN = 48
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  qbt_in_if.sink     in_i,
  qbt_out_if.source  out_o
);

  cmd_t push_cmd, head_cmd;
  wr_t  buf_wr;
  logic push, pop, q_full, q_empty;

  // Front: parser state, buffer writes, one command per closed token (which may carry a one-byte extra token).
  qbt_front #(
    .MAX_TOKEN (MAX_TOKEN)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_full_i (q_full),
    .push_o   (push),
    .cmd_o    (push_cmd),
    .wr_o     (buf_wr)
  );

  // Decoupling queue; each entry pins one of three buffer banks.
  qbt_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (pop),
    .head_o  (head_cmd),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // Back: walks the head command through the buffer into out_o.
  qbt_back #(
    .MAX_TOKEN (MAX_TOKEN)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (buf_wr),
    .cmd_i       (head_cmd),
    .cmd_valid_i (!q_empty),
    .pop_o       (pop),
    .out_o       (out_o)
  );

  // Queue never pushed while full.
  assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> !q_full)
    else $error("token queue overflow");

  // Queue never popped while empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> !q_empty)
    else $error("token queue underflow");

  // An empty quoted token is a single NUL beat that closes the token.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_o.valid && out_o.token_empty |-> out_o.token_last && out_o.token_char == CH_NUL)
    else $error("malformed empty token beat");

  // Buffer write never lands in a bank still owned by the queue head.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      buf_wr.en && !q_empty |-> buf_wr.bank != head_cmd.bank)
    else $error("buffer write into a pending bank");

endmodule
